// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the request and result payload types, the stored entry type,
// the cell control group and the status and opcode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // number of cells in the chain
  localparam int CAPACITY = 128;
  // width of the fill count, able to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // width of the occupancy result field
  localparam int OCC_W = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic [OCC_W-1:0]   occupancy;
  } out_rsp_t;

  // one stored pair
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On an insert it keeps its entry, takes the new entry,
// or takes its left neighbor's entry; on a removal it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occupied,
  input  wire spq_pkg::entry_t     new_entry,
  input  wire spq_pkg::entry_t     left_entry,
  input  wire logic                left_move,
  input  wire spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t          entry,
  output logic                     move
);

  // this slot yields to the new entry when empty or of strictly lower priority
  assign move = !occupied || ($signed(entry.prio) < $signed(new_entry.prio));

  // slot update
  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (left_move) begin
        entry <= left_entry;
      end else if (move) begin
        entry <= new_entry;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: systolic sorted-array priority queue
// A row of cells holds up to CAPACITY entries sorted by descending
// priority, ties in arrival order. Enqueue inserts, dequeue pops the head.
// ----------------------------------------------------------------------------
//  channel  | signals                      | moves
//  ---------+------------------------------+------------------------------
//  in       | in_valid, in_ready, in_data  | enqueue / dequeue request
//  out      | out_valid, out_ready, out_data | status, head, occupancy
//
// One request per cycle: every cell compares against the broadcast priority
// and shifts in the same cycle, and the result is captured in the output
// register on acceptance. in_ready drops only while a result waits on
// out_ready. Reset clears the fill count and the output valid flag; the cell
// contents are not cleared and are read only below the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spq_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spq_pkg::out_rsp_t      out_data
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctrl_t       ctrl;
  spq_pkg::entry_t           new_entry;
  spq_pkg::out_rsp_t         rsp_next;
  spq_pkg::entry_t           cell_entry [N];
  logic                      cell_move  [N];

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == spq_pkg::CNT_W'(N));
  assign empty    = (count == '0);

  assign new_entry.value = in_data.item_value;
  assign new_entry.prio  = in_data.item_priority;

  // decode request, next count and result
  always_comb begin
    ctrl.enq   = 1'b0;
    ctrl.deq   = 1'b0;
    count_next = count;
    rsp_next.status        = spq_pkg::ST_OK;
    rsp_next.head_value    = '0;
    rsp_next.head_priority = '0;
    case (in_data.opcode)
      spq_pkg::OP_ENQ: begin
        if (full) begin
          rsp_next.status = spq_pkg::ST_OVERFLOW;
        end else begin
          ctrl.enq   = accept;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::OP_DEQ: begin
        if (empty) begin
          rsp_next.status = spq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.deq   = accept;
          count_next = count - 1'b1;
          rsp_next.head_value    = cell_entry[0].value;
          rsp_next.head_priority = cell_entry[0].prio;
        end
      end
      default: begin
        rsp_next.status = spq_pkg::ST_OK;
      end
    endcase
    rsp_next.occupancy = spq_pkg::OCC_W'(count_next);
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp_next;
    end
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_move;
    logic            occupied;

    assign occupied = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_move  = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_move  = cell_move[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_move   (left_move),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .move        (cell_move[i])
    );
  end

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire spq_pkg::out_rsp_t out_data
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // an accepted request shows a result next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after request");

  // overflow only when full, underflow only when empty
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == spq_pkg::ST_OVERFLOW) |->
      (out_data.occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY)))
    else $error("overflow below capacity");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == spq_pkg::ST_UNDERFLOW) |->
      (out_data.occupancy == '0 && out_data.head_value == '0 &&
       out_data.head_priority == '0))
    else $error("underflow with data or entries");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

`default_nettype wire
